### design/ggc_pkg.sv
// ---------------------------------------------------------------------------
// ggc_pkg: shared types and constants for the greedy graph coloring unit
// Sizes, group split of the color search, controller states and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package ggc_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int NUM_COLORS   = 64;

	localparam int VW     = $clog2(MAX_VERTICES);  // vertex index width
	localparam int CW     = $clog2(NUM_COLORS);    // color index width
	localparam int CNT_W  = CW + 1;                // color count width
	localparam int POP_W  = 11;
	localparam int POP_LIMIT = (1 << POP_W) - 1;

	// color search splits into groups of eight candidates
	localparam int GS  = 8;
	localparam int GW  = $clog2(GS);
	localparam int NG  = NUM_COLORS / GS;
	localparam int NGW = (NG > 1) ? $clog2(NG) : 1;

	localparam logic KIND_ENTRY = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_MARK,
		ST_GRP,
		ST_PICK,
		ST_WB
	} state_t;

	typedef struct packed {
		logic entry;      // neighbor entry accepted, launch store read
		logic clr_start;  // clear item accepted
		logic clr_walk;   // zeroing sweep in progress
		logic mark;       // fold neighbor color into forbidden mask
		logic grp;        // per-group first-free search
		logic pick;       // final select, population read
		logic wb;         // write back and present result
	} cmd_t;

	typedef struct packed {
		logic clr_done;
	} stat_t;

endpackage

### design/ggc_ctrl.sv
// ---------------------------------------------------------------------------
// ggc_ctrl: sequencing controller
// Walks each accepted entry through mark, and a last entry on through search
// and write back, and runs the zeroing sweep after reset and on a clear item.
// ---------------------------------------------------------------------------
module ggc_ctrl import ggc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  kind,
	input  logic  last_neighbor,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	state_t state_q, state_d;
	logic   last_q;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_q <= last_neighbor;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (stat.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = (kind == KIND_CLEAR) ? ST_CLR : ST_MARK;
			end
			ST_MARK: begin
				state_d = last_q ? ST_GRP : ST_IDLE;
			end
			ST_GRP:  state_d = ST_PICK;
			ST_PICK: state_d = ST_WB;
			ST_WB:   state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.entry     = accept && (kind == KIND_ENTRY);
		cmd.clr_start = accept && (kind == KIND_CLEAR);
		unique case (state_q)
			ST_CLR:  cmd.clr_walk = 1'b1;
			ST_MARK: cmd.mark     = 1'b1;
			ST_GRP:  cmd.grp      = 1'b1;
			ST_PICK: cmd.pick     = 1'b1;
			ST_WB:   cmd.wb       = 1'b1;
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### design/ggc_dp.sv
// ---------------------------------------------------------------------------
// ggc_dp: coloring datapath
// Color store and population memories, forbidden mask, two-level first-fit
// search, color count and result registers.
// ---------------------------------------------------------------------------
module ggc_dp import ggc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [9:0]       vertex_id,
	input  logic [9:0]       neighbor_id,
	input  logic             has_neighbor,
	output stat_t            stat,
	output logic             done,
	output logic [9:0]       colored_vertex,
	output logic [5:0]       assigned_color,
	output logic [6:0]       colors_in_use,
	output logic [10:0]      color_population,
	output logic             overflow
);

	logic [CW-1:0]    store_mem [MAX_VERTICES];
	logic [POP_W-1:0] pop_mem   [NUM_COLORS];

	logic [VW-1:0]       clr_cnt_q;
	logic [VW-1:0]       vid_q;
	logic                has_q;
	logic [CW-1:0]       nc_q;
	logic [NUM_COLORS-1:0] mask_q;
	logic [CNT_W-1:0]    count_q;

	logic [NG-1:0]       grp_any_q;
	logic [GW-1:0]       grp_idx_q [NG];
	logic [NG-1:0]       grp_any_d;
	logic [GW-1:0]       grp_idx_d [NG];

	logic [CW-1:0]       chosen_q;
	logic                found_q;
	logic [POP_W-1:0]    pop_rd_q;

	logic [CNT_W-1:0]    limit;
	logic [NUM_COLORS-1:0] free_vec;
	logic [NGW-1:0]      gsel;
	logic [CW-1:0]       chosen_d;
	logic [POP_W-1:0]    pop_new;
	logic [CNT_W-1:0]    count_d;
	logic                pop_clr;

	logic                done_q;
	logic [9:0]          vtx_q;
	logic [5:0]          color_q;
	logic [6:0]          inuse_q;
	logic [10:0]         pop_q;
	logic                ovf_q;

	assign stat.clr_done = cmd.clr_walk && (clr_cnt_q == VW'(MAX_VERTICES - 1));
	assign pop_clr = cmd.clr_walk && (clr_cnt_q[VW-1:CW] == '0);

	// candidates run from 0 up to the count, capped at the last color
	assign limit = (count_q >= CNT_W'(NUM_COLORS - 1)) ? CNT_W'(NUM_COLORS - 1) : count_q;

	always_comb begin
		for (int c = 0; c < NUM_COLORS; c++) begin
			free_vec[c] = !mask_q[c] && (CNT_W'(c) <= limit);
		end
		for (int g = 0; g < NG; g++) begin
			grp_any_d[g] = 1'b0;
			grp_idx_d[g] = '0;
			for (int i = GS - 1; i >= 0; i--) begin
				if (free_vec[g*GS + i]) begin
					grp_any_d[g] = 1'b1;
					grp_idx_d[g] = GW'(i);
				end
			end
		end
	end

	always_comb begin
		gsel = '0;
		for (int j = NG - 1; j >= 0; j--) begin
			if (grp_any_q[j]) gsel = NGW'(j);
		end
		chosen_d = CW'({gsel, grp_idx_q[gsel]});
	end

	assign pop_new = (pop_rd_q == POP_W'(POP_LIMIT)) ? pop_rd_q : pop_rd_q + 1'b1;
	assign count_d = (found_q && ({1'b0, chosen_q} == count_q) &&
			(count_q < CNT_W'(NUM_COLORS))) ? count_q + 1'b1 : count_q;

	// memories
	always_ff @(posedge clk) begin
		if (cmd.clr_walk) begin
			store_mem[clr_cnt_q] <= '0;
		end else if (cmd.wb && found_q) begin
			store_mem[vid_q] <= chosen_q;
		end
		if (cmd.entry) begin
			nc_q <= store_mem[neighbor_id[VW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pop_clr) begin
			pop_mem[clr_cnt_q[CW-1:0]] <= '0;
		end else if (cmd.wb && found_q) begin
			pop_mem[chosen_q] <= pop_new;
		end
		if (cmd.pick) begin
			pop_rd_q <= pop_mem[chosen_d];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.entry) begin
			vid_q <= vertex_id[VW-1:0];
			has_q <= has_neighbor;
		end
		if (cmd.grp) begin
			grp_idx_q <= grp_idx_d;
		end
		if (cmd.pick) begin
			chosen_q <= chosen_d;
		end
		if (cmd.wb) begin
			vtx_q   <= 10'(vid_q);
			color_q <= found_q ? 6'(chosen_q) : '0;
			inuse_q <= 7'(count_d);
			pop_q   <= found_q ? 11'(pop_new) : '0;
			ovf_q   <= !found_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			mask_q    <= '0;
			count_q   <= CNT_W'(1);
			grp_any_q <= '0;
			found_q   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.wb;
			if (cmd.clr_start) begin
				clr_cnt_q <= '0;
				mask_q    <= '0;
				count_q   <= CNT_W'(1);
			end else if (cmd.clr_walk) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.mark && has_q) begin
				mask_q[nc_q] <= 1'b1;
			end
			if (cmd.grp) begin
				grp_any_q <= grp_any_d;
			end
			if (cmd.pick) begin
				found_q <= |grp_any_q;
				mask_q  <= '0;
			end
			if (cmd.wb) begin
				count_q <= count_d;
			end
		end
	end

	assign done             = done_q;
	assign colored_vertex   = vtx_q;
	assign assigned_color   = color_q;
	assign colors_in_use    = inuse_q;
	assign color_population = pop_q;
	assign overflow         = ovf_q;

endmodule

### design/greedy_graph_coloring_unit.sv
// ---------------------------------------------------------------------------
// greedy_graph_coloring_unit: first-fit greedy vertex coloring
// Neighbor entries mark the colors of adjacent vertices as forbidden; the
// last entry of a vertex assigns the lowest free color and reports it.
//
//   channel   handshake           payload
//   -------   -----------------   ---------------------------------------
//   command   start / busy        kind, vertex_id, neighbor_id,
//                                 has_neighbor, last_neighbor
//   result    done (1 cycle)      colored_vertex, assigned_color,
//                                 colors_in_use, color_population, overflow
//
// A neighbor entry is a registered color store read followed by a mark of
// the mask. A last entry goes on through group search, final select with
// population read and write back; done follows in the next cycle.
// After reset and after a clear item the color store is zeroed in a sweep
// over all 1024 entries, one entry a cycle, while busy stays high.
// done cannot be held off by the receiver; the result is valid only then.
// ---------------------------------------------------------------------------
module greedy_graph_coloring_unit import ggc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [9:0]  vertex_id,
	input  logic [9:0]  neighbor_id,
	input  logic        has_neighbor,
	input  logic        last_neighbor,
	output logic        done,
	output logic [9:0]  colored_vertex,
	output logic [5:0]  assigned_color,
	output logic [6:0]  colors_in_use,
	output logic [10:0] color_population,
	output logic        overflow
);

	cmd_t  cmd;
	stat_t stat;

	ggc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.kind          (kind),
		.last_neighbor (last_neighbor),
		.stat          (stat),
		.cmd           (cmd),
		.busy          (busy)
	);

	ggc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.vertex_id        (vertex_id),
		.neighbor_id      (neighbor_id),
		.has_neighbor     (has_neighbor),
		.stat             (stat),
		.done             (done),
		.colored_vertex   (colored_vertex),
		.assigned_color   (assigned_color),
		.colors_in_use    (colors_in_use),
		.color_population (color_population),
		.overflow         (overflow)
	);

endmodule

### design/ggc_checker.sv
// ---------------------------------------------------------------------------
// ggc_checker: port-level checks for the coloring unit
// Result timing against the command handshake and consistency of the
// result fields.
// ---------------------------------------------------------------------------
module ggc_checker import ggc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [5:0]  assigned_color,
	input logic [6:0]  colors_in_use,
	input logic [10:0] color_population,
	input logic        overflow
);

	// a result only ends a multi-cycle item and frees the unit at once
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result without a preceding busy item");

	// an accepted transfer always occupies the unit for the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// overflow zeroes the color fields; a colored vertex counts itself
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (overflow ? (assigned_color == '0 && color_population == '0)
			: (color_population != '0 && 7'(assigned_color) < colors_in_use)))
		else $error("inconsistent result fields");

	// a fresh color is always free below the cap, so overflow needs a full palette
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (colors_in_use == 7'(NUM_COLORS)))
		else $error("overflow with colors still unused");

endmodule

bind greedy_graph_coloring_unit ggc_checker u_ggc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.assigned_color   (assigned_color),
	.colors_in_use    (colors_in_use),
	.color_population (color_population),
	.overflow         (overflow)
);

### tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for greedy_graph_coloring_unit
// Drives vertex runs of neighbor entries through the start/busy command port
// and checks every done strobe against a shadow first-fit colorer or a typed
// row expectation. A short directed table comes first; random runs over small
// and large vertex pools follow, abandoned runs and stray clears mixed in.
// ---------------------------------------------------------------------------
module testbench import ggc_pkg::*; ();

	localparam int RANDOM_ITEMS = 1750;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [9:0]  vertex;
		logic [5:0]  color;
		logic [6:0]  ncolors;
		logic [10:0] pop;
		logic        ovf;
	} coloring_t;

	typedef struct packed {
		logic       k;
		logic [9:0] v;
		logic [9:0] n;
		logic       h;
		logic       l;
		logic       typed;
		coloring_t  res;
	} row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        kind = KIND_ENTRY;
	logic [9:0]  vertex_id = '0;
	logic [9:0]  neighbor_id = '0;
	logic        has_neighbor = 1'b0;
	logic        last_neighbor = 1'b0;
	logic        done;
	logic [9:0]  colored_vertex;
	logic [5:0]  assigned_color;
	logic [6:0]  colors_in_use;
	logic [10:0] color_population;
	logic        overflow;

	// expectation typed into the directed table, travels with the transfer
	logic        row_has_expect = 1'b0;
	coloring_t   row_expect = '0;

	// shadow colorer state
	logic [5:0]  shadow_color [MAX_VERTICES];
	logic [63:0] shadow_forbid;
	logic [6:0]  shadow_ncolors;
	logic [10:0] shadow_pop [NUM_COLORS];

	coloring_t   expected_colorings [$];
	int          errors = 0;
	int          cycles = 0;
	int          items_sent = 0;
	bit          no_idle = 1'b0;
	logic [9:0]  pool_base = '0;

	row_t directed_rows [18] = '{
		'{KIND_ENTRY, 10'd5,    10'd0,    1'b0, 1'b1, 1'b1, '{10'd5,    6'd0, 7'd1, 11'd1, 1'b0}},
		'{KIND_ENTRY, 10'd6,    10'd5,    1'b1, 1'b1, 1'b1, '{10'd6,    6'd1, 7'd2, 11'd1, 1'b0}},
		'{KIND_ENTRY, 10'd1023, 10'd1023, 1'b1, 1'b0, 1'b0, '0},
		'{KIND_ENTRY, 10'd1023, 10'd6,    1'b1, 1'b1, 1'b1, '{10'd1023, 6'd2, 7'd3, 11'd1, 1'b0}},
		'{KIND_ENTRY, 10'd0,    10'd0,    1'b1, 1'b0, 1'b0, '0},
		'{KIND_ENTRY, 10'd0,    10'd1023, 1'b0, 1'b0, 1'b0, '0},
		'{KIND_ENTRY, 10'd0,    10'd1023, 1'b1, 1'b1, 1'b1, '{10'd0,    6'd1, 7'd3, 11'd2, 1'b0}},
		'{KIND_ENTRY, 10'd5,    10'd1023, 1'b1, 1'b1, 1'b1, '{10'd5,    6'd0, 7'd3, 11'd2, 1'b0}},
		'{KIND_ENTRY, 10'd512,  10'd6,    1'b1, 1'b0, 1'b0, '0},
		'{KIND_ENTRY, 10'd512,  10'd1023, 1'b1, 1'b0, 1'b0, '0},
		'{KIND_ENTRY, 10'd512,  10'd0,    1'b1, 1'b0, 1'b0, '0},
		'{KIND_ENTRY, 10'd512,  10'd5,    1'b1, 1'b1, 1'b0, '0},
		'{KIND_CLEAR, 10'd1023, 10'd1023, 1'b1, 1'b1, 1'b0, '0},
		'{KIND_ENTRY, 10'd6,    10'd512,  1'b1, 1'b1, 1'b1, '{10'd6,    6'd1, 7'd2, 11'd1, 1'b0}},
		'{KIND_CLEAR, 10'd0,    10'd0,    1'b0, 1'b0, 1'b0, '0},
		'{KIND_ENTRY, 10'd341,  10'd682,  1'b1, 1'b1, 1'b1, '{10'd341,  6'd1, 7'd2, 11'd1, 1'b0}},
		'{KIND_ENTRY, 10'd682,  10'd341,  1'b1, 1'b1, 1'b1, '{10'd682,  6'd0, 7'd2, 11'd1, 1'b0}},
		'{KIND_ENTRY, 10'd100,  10'd100,  1'b1, 1'b1, 1'b1, '{10'd100,  6'd1, 7'd2, 11'd2, 1'b0}}
	};

	greedy_graph_coloring_unit u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.kind             (kind),
		.vertex_id        (vertex_id),
		.neighbor_id      (neighbor_id),
		.has_neighbor     (has_neighbor),
		.last_neighbor    (last_neighbor),
		.done             (done),
		.colored_vertex   (colored_vertex),
		.assigned_color   (assigned_color),
		.colors_in_use    (colors_in_use),
		.color_population (color_population),
		.overflow         (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d colorings outstanding", $time,
				expected_colorings.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic clear_shadow();
		int i;
		for (i = 0; i < MAX_VERTICES; i++)
			shadow_color[i] = '0;
		for (i = 0; i < NUM_COLORS; i++)
			shadow_pop[i] = '0;
		shadow_forbid = '0;
		shadow_ncolors = 7'd1;
	endtask

	// first-fit pick over 0..count, capped below NUM_COLORS
	task automatic predict_coloring(input logic k, input logic [9:0] v, input logic [9:0] n,
			input logic h, input logic l, output logic produced, output coloring_t res);
		int limit;
		int pick;
		int c;
		produced = 1'b0;
		res = '0;
		if (k == KIND_CLEAR) begin
			clear_shadow();
		end else begin
			if (h)
				shadow_forbid[shadow_color[n]] = 1'b1;
			if (l) begin
				limit = (shadow_ncolors > NUM_COLORS - 1) ? NUM_COLORS - 1 : shadow_ncolors;
				pick = -1;
				for (c = 0; c <= limit && pick < 0; c++)
					if (!shadow_forbid[c])
						pick = c;
				shadow_forbid = '0;
				produced = 1'b1;
				res.vertex = v;
				res.ovf = (pick < 0);
				if (pick >= 0) begin
					shadow_color[v] = 6'(pick);
					if (pick == shadow_ncolors && shadow_ncolors < NUM_COLORS)
						shadow_ncolors = shadow_ncolors + 7'd1;
					if (shadow_pop[pick] < POP_LIMIT)
						shadow_pop[pick] = shadow_pop[pick] + 11'd1;
					res.color = 6'(pick);
					res.pop = shadow_pop[pick];
				end
				res.ncolors = shadow_ncolors;
			end
		end
	endtask

	task automatic check_field(input string name, input logic [10:0] want,
			input logic [10:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : monitor
		coloring_t want;
		coloring_t predicted;
		logic      produced;
		if (arst_n) begin
			if (done) begin
				if (expected_colorings.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, vertex %0d", $time, colored_vertex);
				end else begin
					want = expected_colorings.pop_front();
					check_field("colored_vertex", want.vertex, colored_vertex);
					check_field("assigned_color", want.color, assigned_color);
					check_field("colors_in_use", want.ncolors, colors_in_use);
					check_field("color_population", want.pop, color_population);
					check_field("overflow", want.ovf, overflow);
				end
			end
			if (start && !busy) begin
				predict_coloring(kind, vertex_id, neighbor_id, has_neighbor, last_neighbor,
					produced, predicted);
				if (produced)
					expected_colorings.insert(expected_colorings.size(),
						row_has_expect ? row_expect : predicted);
			end
		end
	end

	// one command transfer; returns at the edge that accepts it
	task automatic issue(input logic k, input logic [9:0] v, input logic [9:0] n,
			input logic h, input logic l, input logic typed = 1'b0,
			input coloring_t res = '0);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		vertex_id <= v;
		neighbor_id <= n;
		has_neighbor <= h;
		last_neighbor <= l;
		row_has_expect <= typed;
		row_expect <= res;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic issue_clear();
		issue(KIND_CLEAR, 10'($urandom), 10'($urandom), 1'($urandom), 1'($urandom));
		pool_base = 10'($urandom);
	endtask

	function automatic logic [9:0] pick_vertex(input int pool);
		if (pool == 0)
			return 10'($urandom_range(0, 1023));
		return pool_base + 10'($urandom_range(0, pool - 1));
	endfunction

	// small pools keep neighbors colored so the color count climbs
	task automatic vertex_run(input bit finish_run);
		int pool;
		int count;
		int j;
		logic [9:0] v;
		case ($urandom_range(0, 2))
			0: pool = 0;
			1: pool = 12;
			default: pool = 48;
		endcase
		count = $urandom_range(0, 10);
		v = pick_vertex(pool);
		if (count == 0 && finish_run)
			issue(KIND_ENTRY, v, 10'($urandom), 1'b0, 1'b1);
		for (j = 0; j < count; j++)
			issue(KIND_ENTRY, (j == count - 1) ? v : 10'($urandom), pick_vertex(pool),
				$urandom_range(0, 9) != 0, finish_run && j == count - 1);
	endtask

	initial begin
		int r;
		int sel;
		int mark;
		int general;
		clear_shadow();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (r = 0; r < 18; r++) begin
			no_idle = ($urandom_range(0, 2) == 0);
			issue(directed_rows[r].k, directed_rows[r].v, directed_rows[r].n,
				directed_rows[r].h, directed_rows[r].l, directed_rows[r].typed,
				directed_rows[r].res);
		end

		general = 0;
		pool_base = 10'($urandom);
		while (general < RANDOM_ITEMS) begin
			mark = items_sent;
			no_idle = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 99);
			if (sel < 3) begin
				// run abandoned before its last entry
				vertex_run(1'b0);
				issue_clear();
			end else if (sel < 9) begin
				issue(($urandom_range(0, 7) == 0) ? KIND_CLEAR : KIND_ENTRY,
					10'($urandom), 10'($urandom), 1'($urandom), 1'($urandom));
			end else begin
				vertex_run(1'b1);
			end
			general += items_sent - mark;
		end
		start <= 1'b0;

		while (expected_colorings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### files.f
design/ggc_pkg.sv
design/ggc_ctrl.sv
design/ggc_dp.sv
design/greedy_graph_coloring_unit.sv
design/ggc_checker.sv
tb/testbench.sv
